// ===== rtl/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdd_pkg: Gregorian date difference shared definitions
// Field widths, pipeline stage records and calendar tables.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DAYS_W   = 23;
    localparam int AGE_W    = 15;

    // Serial of 16383-12-31 is below 2**23
    localparam int SERIAL_W = 23;
    // floor(y / 100) for y < 16384 is at most 163
    localparam int CENT_W   = 8;
    // leap days before year 16383 stay below 4096
    localparam int LEAPS_W  = 12;

    // floor(y / 100) == (y * 5243) >> 19, exact for y + 99 < 2**14 + 99
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 23'd365;

    // Date index within a beat
    localparam int BIRTH = 0;
    localparam int TODAY = 1;
    localparam int NUM_DATES = 2;

    // Stage 1: raw date plus century quotient
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [CENT_W-1:0]  cent;
    } t_date_s1;

    // Stage 2: leap info and validity
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [LEAPS_W-1:0] leaps;
        logic               leap;
        logic               ok;
    } t_date_s2;

    // Stage 3: finished day serial
    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [YEAR_W-1:0]   year;
        logic                ok;
    } t_date_s3;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] dbm;
        case (m)
            4'd2:    dbm = 9'd31;
            4'd3:    dbm = 9'd59;
            4'd4:    dbm = 9'd90;
            4'd5:    dbm = 9'd120;
            4'd6:    dbm = 9'd151;
            4'd7:    dbm = 9'd181;
            4'd8:    dbm = 9'd212;
            4'd9:    dbm = 9'd243;
            4'd10:   dbm = 9'd273;
            4'd11:   dbm = 9'd304;
            4'd12:   dbm = 9'd334;
            default: dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage

// ===== rtl/gdd_in_if.sv =====
// ----------------------------------------------------------------------------
// gdd_in_if: input channel
// Valid/ready channel carrying the two dates of one beat.
// ----------------------------------------------------------------------------
interface gdd_in_if import gdd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   birth_day;
    logic [MONTH_W-1:0] birth_month;
    logic [YEAR_W-1:0]  birth_year;
    logic [DAY_W-1:0]   today_day;
    logic [MONTH_W-1:0] today_month;
    logic [YEAR_W-1:0]  today_year;

    modport source (
        output valid, birth_day, birth_month, birth_year,
               today_day, today_month, today_year,
        input  ready
    );

    modport sink (
        input  valid, birth_day, birth_month, birth_year,
               today_day, today_month, today_year,
        output ready
    );
endinterface

// ===== rtl/gdd_out_if.sv =====
// ----------------------------------------------------------------------------
// gdd_out_if: result channel
// Valid/ready channel carrying validity flags, day difference and age.
// ----------------------------------------------------------------------------
interface gdd_out_if import gdd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     first_ok;
    logic                     second_ok;
    logic signed [DAYS_W-1:0] days_apart;
    logic signed [AGE_W-1:0]  age_years;

    modport source (
        output valid, first_ok, second_ok, days_apart, age_years,
        input  ready
    );

    modport sink (
        input  valid, first_ok, second_ok, days_apart, age_years,
        output ready
    );
endinterface

// ===== rtl/gregorian_date_difference_top.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_difference_top: days and whole years between two dates
// Four-stage pipeline: validity check, day serials, difference and age.
// ----------------------------------------------------------------------------
// Each input beat carries a birth date and a today date (proleptic Gregorian,
// year 0 is a leap year). Each date is flagged valid when its year is at most
// MAX_YEAR, its month is 1..12 and its day is 1..month length. When both are
// valid the result beat gives today's day serial minus the birth serial and
// the completed years between them (negative when today is earlier); otherwise
// both numbers are zero. Every input beat yields exactly one result beat.
// A beat passes through four register stages (century quotient, leap and validity,
// serial, difference), each advancing independently; a new beat is taken every
// cycle unless the result is stalled and the pipeline is full. A stalled
// result holds only the output stage; earlier stages keep filling until full.
// ----------------------------------------------------------------------------
module gregorian_date_difference_top import gdd_pkg::*; #(
    parameter int MAX_YEAR = 9999
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdd_in_if.sink    i_in,
    gdd_out_if.source o_out
);

    localparam int LIMIT_W = 17;
    localparam logic [LIMIT_W-1:0] YEAR_LIMIT = LIMIT_W'(MAX_YEAR);

    // ---- stage enables: a stage moves when it is empty or its successor moves
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || o_out.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // ---- stage 1: century quotient by reciprocal multiply, month/day order
    t_date_s1 r_s1 [NUM_DATES];
    t_date_s1 n_s1 [NUM_DATES];
    logic     r_before1, n_before1;

    logic [DAY_W-1:0]   in_day   [NUM_DATES];
    logic [MONTH_W-1:0] in_month [NUM_DATES];
    logic [YEAR_W-1:0]  in_year  [NUM_DATES];

    assign in_day[BIRTH]   = i_in.birth_day;
    assign in_month[BIRTH] = i_in.birth_month;
    assign in_year[BIRTH]  = i_in.birth_year;
    assign in_day[TODAY]   = i_in.today_day;
    assign in_month[TODAY] = i_in.today_month;
    assign in_year[TODAY]  = i_in.today_year;

    always_comb begin
        logic [YEAR_W+RECIP_W-1:0] prod;
        for (int k = 0; k < NUM_DATES; k++) begin
            prod = (YEAR_W+RECIP_W)'(in_year[k]) * (YEAR_W+RECIP_W)'(RECIP_100);
            n_s1[k].day   = in_day[k];
            n_s1[k].month = in_month[k];
            n_s1[k].year  = in_year[k];
            n_s1[k].cent  = prod[RECIP_SHIFT +: CENT_W];
        end
        // birthday not yet reached in today's year
        n_before1 = (i_in.today_month < i_in.birth_month) ||
                    ((i_in.today_month == i_in.birth_month) &&
                     (i_in.today_day < i_in.birth_day));
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1      <= n_s1;
            r_before1 <= n_before1;
        end
    end

    // ---- stage 2: leap year, leap-day count before the year, validity
    t_date_s2 r_s2 [NUM_DATES];
    t_date_s2 n_s2 [NUM_DATES];
    logic     r_before2;

    always_comb begin
        logic                rem_nz;
        logic [CENT_W-1:0]   c100;
        logic [CENT_W:0]     c400_sum;
        logic [YEAR_W:0]     c4_sum;
        logic [LEAPS_W:0]    leaps;
        logic [LIMIT_W-1:0]  year_x;
        logic                leap;
        for (int k = 0; k < NUM_DATES; k++) begin
            rem_nz   = r_s1[k].year != (YEAR_W'(r_s1[k].cent) * YEAR_W'(100));
            c100     = r_s1[k].cent + CENT_W'(rem_nz);           // ceil(y/100)
            c400_sum = (CENT_W+1)'(c100) + (CENT_W+1)'(3);       // ceil(y/400)
            c4_sum   = (YEAR_W+1)'(r_s1[k].year) + (YEAR_W+1)'(3);
            leaps    = (LEAPS_W+1)'(c4_sum[YEAR_W:2]) - (LEAPS_W+1)'(c100)
                     + (LEAPS_W+1)'(c400_sum[CENT_W:2]);
            leap     = (r_s1[k].year[1:0] == 2'b00) &&
                       (rem_nz || (r_s1[k].cent[1:0] == 2'b00));
            year_x   = LIMIT_W'(r_s1[k].year);

            n_s2[k].day   = r_s1[k].day;
            n_s2[k].month = r_s1[k].month;
            n_s2[k].year  = r_s1[k].year;
            n_s2[k].leaps = leaps[LEAPS_W-1:0];
            n_s2[k].leap  = leap;
            n_s2[k].ok    = (year_x <= YEAR_LIMIT) &&
                            (r_s1[k].month >= MONTH_JAN) &&
                            (r_s1[k].month <= MONTH_DEC) &&
                            (r_s1[k].day != '0) &&
                            (r_s1[k].day <= month_len(r_s1[k].month, leap));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2      <= n_s2;
            r_before2 <= r_before1;
        end
    end

    // ---- stage 3: day serial = 365*y + leaps + days before month + day (+1 after Feb in a leap year)
    t_date_s3 r_s3 [NUM_DATES];
    t_date_s3 n_s3 [NUM_DATES];
    logic     r_before3;

    always_comb begin
        for (int k = 0; k < NUM_DATES; k++) begin
            n_s3[k].serial = SERIAL_W'(r_s2[k].year) * DAYS_PER_YEAR
                           + SERIAL_W'(r_s2[k].leaps)
                           + SERIAL_W'(days_before(r_s2[k].month))
                           + SERIAL_W'(r_s2[k].day)
                           + SERIAL_W'((r_s2[k].month > MONTH_FEB) && r_s2[k].leap);
            n_s3[k].year   = r_s2[k].year;
            n_s3[k].ok     = r_s2[k].ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3      <= n_s3;
            r_before3 <= r_before2;
        end
    end

    // ---- stage 4: difference, age, zeroing on an invalid date
    logic                     both_ok;
    logic [DAYS_W-1:0]        n_days;
    logic [AGE_W-1:0]         n_age;
    logic                     r_first_ok, r_second_ok;
    logic signed [DAYS_W-1:0] r_days;
    logic signed [AGE_W-1:0]  r_age;

    assign both_ok = r_s3[BIRTH].ok && r_s3[TODAY].ok;

    always_comb begin
        n_days = '0;
        n_age  = '0;
        if (both_ok) begin
            n_days = DAYS_W'(r_s3[TODAY].serial - r_s3[BIRTH].serial);
            n_age  = AGE_W'(r_s3[TODAY].year) - AGE_W'(r_s3[BIRTH].year)
                   - AGE_W'(r_before3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_first_ok  <= r_s3[BIRTH].ok;
            r_second_ok <= r_s3[TODAY].ok;
            r_days      <= signed'(n_days);
            r_age       <= signed'(n_age);
        end
    end

    assign o_out.valid      = r_v4;
    assign o_out.first_ok   = r_first_ok;
    assign o_out.second_ok  = r_second_ok;
    assign o_out.days_apart = r_days;
    assign o_out.age_years  = r_age;

    // ---- checks
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v4 |-> i_in.ready)
        else $error("input not ready with empty output stage");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !o_out.ready) |-> !i_in.ready)
        else $error("input ready while pipeline full and stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !(r_first_ok && r_second_ok)) |-> (r_days == '0 && r_age == '0))
        else $error("nonzero result for an invalid date");

    a_sign_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_days[DAYS_W-1]) |-> !r_age[AGE_W-1])
        else $error("negative age with nonnegative day difference");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: gregorian_date_difference_top checker
// Sends pairs of calendar dates through the valid/ready input channel and
// compares every result beat with a software calculation of the same pair:
// validity flags, signed day difference and completed years. Directed corner
// dates come first, then random pairs under several idle and stall patterns.
// ----------------------------------------------------------------------------
package gdd_tb_pkg;
    import gdd_pkg::*;

    localparam int LAST_YEAR = 9999;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } cal_date_t;

    typedef struct packed {
        cal_date_t birth;
        cal_date_t today;
    } date_pair_t;

    typedef struct packed {
        logic                     first_ok;
        logic                     second_ok;
        logic signed [DAYS_W-1:0] days_apart;
        logic signed [AGE_W-1:0]  age_years;
    } span_t;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int m, int y);
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        return 31;
    endfunction

    function automatic bit date_ok(cal_date_t d);
        if (int'(d.year) > LAST_YEAR)
            return 1'b0;
        if (d.month < 1 || d.month > 12)
            return 1'b0;
        return d.day >= 1 && int'(d.day) <= month_days(d.month, d.year);
    endfunction

    // Day count from 0000-01-01 (which counts as 1); only called on valid dates
    function automatic int day_number(cal_date_t d);
        int month_offset [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                  304, 334, 0, 0, 0};
        int y;
        int leaps;
        int n;
        y = d.year;
        leaps = (y > 0) ? (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 : 0;
        n = 365 * y + leaps + month_offset[d.month] + d.day;
        if (d.month > 2 && leap_year(y))
            n++;
        return n;
    endfunction

    function automatic span_t predict_span(date_pair_t p);
        span_t r;
        bit    ok_b;
        bit    ok_t;
        int    days;
        int    age;
        ok_b = date_ok(p.birth);
        ok_t = date_ok(p.today);
        days = 0;
        age  = 0;
        if (ok_b && ok_t) begin
            days = day_number(p.today) - day_number(p.birth);
            age  = int'(p.today.year) - int'(p.birth.year);
            // birthday not reached yet in the today year
            if (p.today.month < p.birth.month ||
                (p.today.month == p.birth.month && p.today.day < p.birth.day))
                age--;
        end
        r.first_ok   = ok_b;
        r.second_ok  = ok_t;
        r.days_apart = days[DAYS_W-1:0];
        r.age_years  = age[AGE_W-1:0];
        return r;
    endfunction

    function automatic cal_date_t make_date(int d, int m, int y);
        cal_date_t c;
        c.day   = d[DAY_W-1:0];
        c.month = m[MONTH_W-1:0];
        c.year  = y[YEAR_W-1:0];
        return c;
    endfunction

    function automatic date_pair_t make_pair(int bd, int bm, int by,
                                             int td, int tm, int ty);
        date_pair_t p;
        p.birth = make_date(bd, bm, by);
        p.today = make_date(td, tm, ty);
        return p;
    endfunction

    // Years weighted toward leap rules and range ends
    function automatic int pick_year();
        case ($urandom_range(0, 9))
            0:       return 100 * $urandom_range(0, 99);
            1:       return 4 * $urandom_range(0, 2499);
            2:       return $urandom_range(0, 4);
            3:       return $urandom_range(LAST_YEAR - 4, LAST_YEAR);
            default: return $urandom_range(0, LAST_YEAR);
        endcase
    endfunction

    function automatic cal_date_t good_date();
        int y;
        int m;
        y = pick_year();
        m = $urandom_range(1, 12);
        return make_date($urandom_range(1, month_days(m, y)), m, y);
    endfunction

    function automatic cal_date_t bad_date();
        cal_date_t d;
        int        m;
        d = good_date();
        case ($urandom_range(0, 4))
            0: d.day = '0;
            1: begin
                // day past the end of a short month
                case ($urandom_range(0, 4))
                    0:       m = 2;
                    1:       m = 4;
                    2:       m = 6;
                    3:       m = 9;
                    default: m = 11;
                endcase
                d.month = m[MONTH_W-1:0];
                d.day   = DAY_W'($urandom_range(month_days(m, d.year) + 1, 31));
            end
            2: d.month = ($urandom_range(0, 3) == 0) ? MONTH_W'(0)
                                                      : MONTH_W'($urandom_range(13, 15));
            3: d.year  = YEAR_W'($urandom_range(LAST_YEAR + 1, (1 << YEAR_W) - 1));
            default: d = cal_date_t'($urandom);
        endcase
        return d;
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t p;
        int         r;
        int         nd;
        r = $urandom_range(0, 99);
        p.birth = good_date();
        p.today = good_date();
        if (r < 60) begin
            // two independent valid dates
        end else if (r < 78) begin
            // same month, day near the birthday: exercises the age step
            p.today.month = p.birth.month;
            nd = int'(p.birth.day) + $urandom_range(0, 2) - 1;
            if (nd >= 1 && nd <= month_days(p.birth.month, p.today.year))
                p.today.day = nd[DAY_W-1:0];
            else
                p.today.day = 1;
        end else if (r < 86) begin
            if ($urandom_range(0, 1))
                p.birth = bad_date();
            else
                p.today = bad_date();
        end else if (r < 93) begin
            p.birth = bad_date();
            p.today = bad_date();
        end else begin
            p.birth = cal_date_t'($urandom);
            p.today = cal_date_t'($urandom);
        end
        return p;
    endfunction

    // Expected spans in order, checked against result beats
    class span_scoreboard;
        span_t expected_q[$];
        int    errors;
        int    n_dates;
        int    n_both_ok;
        int    n_backward;
        int    n_checked;

        task note_dates(date_pair_t p);
            span_t s;
            s = predict_span(p);
            expected_q.push_back(s);
            n_dates++;
            if (s.first_ok && s.second_ok)
                n_both_ok++;
            if (s.days_apart < 0)
                n_backward++;
        endtask

        task check_span(span_t got);
            span_t exp_s;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with no pending dates: %p", got));
            end else begin
                exp_s = expected_q.pop_front();
                if (got.first_ok !== exp_s.first_ok)
                    report($sformatf("#%0d first_ok %b, want %b",
                                     n_checked, got.first_ok, exp_s.first_ok));
                if (got.second_ok !== exp_s.second_ok)
                    report($sformatf("#%0d second_ok %b, want %b",
                                     n_checked, got.second_ok, exp_s.second_ok));
                if (got.days_apart !== exp_s.days_apart)
                    report($sformatf("#%0d days_apart %0d, want %0d",
                                     n_checked, got.days_apart, exp_s.days_apart));
                if (got.age_years !== exp_s.age_years)
                    report($sformatf("#%0d age_years %0d, want %0d",
                                     n_checked, got.age_years, exp_s.age_years));
            end
            n_checked++;
        endtask

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

module testbench;
    import gdd_pkg::*;
    import gdd_tb_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int PHASE_ITEMS    = 420;
    localparam int SINK_HOLD_CYC  = 48;    // long receiver hold-off, fills the pipe
    localparam int SETTLE_CYC     = 8;     // pipeline is four stages deep
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gdd_in_if  in_ch ();
    gdd_out_if out_ch ();

    gregorian_date_difference_top #(
        .MAX_YEAR (LAST_YEAR)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    span_scoreboard sb = new();

    // Idle pattern switches, flipped by the stimulus between phases
    bit src_idle      = 1'b0;
    bit sink_idle     = 1'b0;
    bit sink_hold_req = 1'b0;
    int idle_cycles   = 0;

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge, plus the watchdog.
    // Acceptance is judged on pre-edge values, so process order at the edge
    // does not matter.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        date_pair_t p;
        span_t      got;
        bit         moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                p.birth = make_date(in_ch.birth_day, in_ch.birth_month, in_ch.birth_year);
                p.today = make_date(in_ch.today_day, in_ch.today_month, in_ch.today_year);
                sb.note_dates(p);
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.first_ok   = out_ch.first_ok;
                got.second_ok  = out_ch.second_ok;
                got.days_apart = out_ch.days_apart;
                got.age_years  = out_ch.age_years;
                sb.check_span(got);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results pending",
                         idle_cycles, sb.pending());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side ready. Random stalls when enabled; a hold request drops
    // ready for a fixed stretch while the sender keeps pushing beats, so the
    // pipe fills and input ready must fall.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYC) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                gap = sink_idle ? pick_gap() : 0;
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                out_ch.ready <= 1'b1;
            end
        end
    end

    // One beat on the input side; returns at the accepting edge. Valid is
    // left high so a following beat can go out back to back.
    task automatic send_dates(date_pair_t p);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.birth_day   <= p.birth.day;
        in_ch.birth_month <= p.birth.month;
        in_ch.birth_year  <= p.birth.year;
        in_ch.today_day   <= p.today.day;
        in_ch.today_month <= p.today.month;
        in_ch.today_year  <= p.today.year;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Sender goes quiet until every pending result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        repeat (count) send_dates(random_pair());
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        date_pair_t directed[$];

        in_ch.valid       = 1'b0;
        in_ch.birth_day   = '0;
        in_ch.birth_month = '0;
        in_ch.birth_year  = '0;
        in_ch.today_day   = '0;
        in_ch.today_month = '0;
        in_ch.today_year  = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // widest spans, both directions, and a zero span
        directed.push_back(make_pair( 1,  1,    0, 31, 12, 9999));
        directed.push_back(make_pair(31, 12, 9999,  1,  1,    0));
        directed.push_back(make_pair(15,  7, 1969, 15,  7, 1969));
        // leap rules: 400 rule, 100 rule, plain non-leap, year zero
        directed.push_back(make_pair(29,  2, 2000, 29,  2, 2024));
        directed.push_back(make_pair(29,  2, 1900,  1,  3, 1900));
        directed.push_back(make_pair( 1,  1, 2023, 29,  2, 2023));
        directed.push_back(make_pair(29,  2,    0,  1,  3,    0));
        directed.push_back(make_pair(28,  2, 2100,  1,  3, 2100));
        // day range per month length
        directed.push_back(make_pair( 0,  5, 2010, 10,  5, 2010));
        directed.push_back(make_pair(31,  4, 2010, 31, 12, 2010));
        directed.push_back(make_pair(30,  9, 1999, 31,  1, 2000));
        // bad months
        directed.push_back(make_pair( 1,  0, 1980,  1, 13, 1980));
        directed.push_back(make_pair(10, 15, 1980, 10,  6, 1980));
        // year limit and the top of the year field
        directed.push_back(make_pair( 1,  1, 9999,  1,  1, 10000));
        directed.push_back(make_pair(31, 12, 16383, 1,  1, 2000));
        directed.push_back(make_pair(31, 15, 16383, 31, 15, 16383));
        directed.push_back(make_pair( 0,  0,    0,  0,  0,    0));
        // age when the second date is earlier, and around a birthday
        directed.push_back(make_pair(10,  6, 2000,  1,  1, 1990));
        directed.push_back(make_pair(10,  6, 2000,  9,  6, 2010));
        directed.push_back(make_pair(10,  6, 2000, 10,  6, 2010));
        directed.push_back(make_pair(10,  6, 2000, 11,  6, 1990));
        directed.push_back(make_pair(29,  2, 2004, 28,  2, 2005));
        directed.push_back(make_pair(31, 12, 1999,  1,  1, 2000));

        foreach (directed[i])
            send_dates(directed[i]);
        wait_drained();

        // full rate both sides
        send_random(PHASE_ITEMS);
        wait_drained();

        // sender gaps only
        src_idle = 1'b1;
        send_random(PHASE_ITEMS);
        wait_drained();

        // receiver stalls, opened by one long hold-off against a busy sender
        src_idle      = 1'b0;
        sink_idle     = 1'b1;
        sink_hold_req = 1'b1;
        send_random(PHASE_ITEMS);
        wait_drained();

        // both sides idle at random
        src_idle = 1'b1;
        send_random(PHASE_ITEMS);
        wait_drained();

        repeat (SETTLE_CYC) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.report("expected result never arrived");

        $display("Checked %0d date pairs: %0d with both dates valid, %0d going backward.",
                 sb.n_checked, sb.n_both_ok, sb.n_backward);
        $display("Idle patterns run: none, sender gaps, receiver stalls with a long hold, both.");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
